### hdl/positional_insert_remove_list_top_defines.svh
// Assertion macros for the positional insert/remove list.
`ifndef POSITIONAL_INSERT_REMOVE_LIST_TOP_DEFINES_SVH
`define POSITIONAL_INSERT_REMOVE_LIST_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PIRL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PIRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/pirl_pkg.sv
// Shared widths, codes and controller/datapath interface types for the list.
package pirl_pkg;

	localparam int ACT_W     = 2;
	localparam int POS_W     = 4;
	localparam int CNT_W     = 4;
	localparam int CAP_W     = 4;
	localparam int DATA_W    = 32;
	localparam int STAT_W    = 2;
	localparam int DEPTH_DEF = 8;
	// capacity register is 4 bits, so no more than this many slots are ever used
	localparam int MAX_SLOTS = (1 << CAP_W) - 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

	localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_DUMP   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_POS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	typedef struct packed {
		logic capture;  // latch the input word
		logic exec;     // perform the operation and load its single result
		logic ptr_clr;  // start a dump
		logic emit;     // load the next dump element
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;   // output register can take a word this cycle
		logic is_dump;
		logic count_zero;
		logic dump_last;
	} dp_stat_t;

endpackage

### hdl/positional_insert_remove_list_top.sv
// Top level of the fixed-capacity positional insert/remove list.
//
//  port group   dir  flow control          payload
//  in_*         in   in_valid / in_stall   action, position, item_value
//  out_*        out  out_valid / out_stall status, element_data, element_valid,
//                                          end_of_run, element_count, is_empty, is_full
//  cfg_*        in   cfg_write_en          cfg_write_data (active capacity)
//
// Append, insert and remove: accept, then an execute step in which all slots update
// in parallel. A dump walks the list through the single read port of the entry bank,
// one output word per cycle while the output is not stalled (empty: a single word).
// Reset clears the count, sets capacity to 8 and empties the output register.
// A stalled output word holds; the next input word is taken while it waits.
module positional_insert_remove_list_top #(
	parameter int DEPTH = pirl_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic        [pirl_pkg::CAP_W-1:0]  cfg_write_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic        [pirl_pkg::ACT_W-1:0]  action,
	input  logic        [pirl_pkg::POS_W-1:0]  position,
	input  logic signed [pirl_pkg::DATA_W-1:0] item_value,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic        [pirl_pkg::STAT_W-1:0] status,
	output logic signed [pirl_pkg::DATA_W-1:0] element_data,
	output logic                             element_valid,
	output logic                             end_of_run,
	output logic        [pirl_pkg::CNT_W-1:0]  element_count,
	output logic                             is_empty,
	output logic                             is_full
);
	import pirl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	pirl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	pirl_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.action         (action),
		.position       (position),
		.item_value     (item_value),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.element_data   (element_data),
		.element_valid  (element_valid),
		.end_of_run     (end_of_run),
		.element_count  (element_count),
		.is_empty       (is_empty),
		.is_full        (is_full)
	);

endmodule

### hdl/pirl_ctrl.sv
// Sequencing state machine for the list: accept, execute, dump walk.
module pirl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pirl_pkg::dp_stat_t stat,
	output pirl_pkg::dp_cmd_t  cmd
);
	import pirl_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (stat.is_dump && !stat.count_zero) begin
					cmd.ptr_clr = 1'b1;
					state_nxt   = ST_DUMP;
				end else if (stat.out_free) begin
					// single result, including the empty dump
					cmd.exec  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			ST_DUMP: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.dump_last) begin
						state_nxt = ST_IDLE;
					end
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

### hdl/pirl_dp.sv
// Datapath: entry bank with parallel shift, count, capacity register, output register.
module pirl_dp #(
	parameter int DEPTH = pirl_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write_en,
	input  logic        [pirl_pkg::CAP_W-1:0]  cfg_write_data,
	input  logic        [pirl_pkg::ACT_W-1:0]  action,
	input  logic        [pirl_pkg::POS_W-1:0]  position,
	input  logic signed [pirl_pkg::DATA_W-1:0] item_value,
	input  pirl_pkg::dp_cmd_t                cmd,
	output pirl_pkg::dp_stat_t               stat,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic        [pirl_pkg::STAT_W-1:0] status,
	output logic signed [pirl_pkg::DATA_W-1:0] element_data,
	output logic                             element_valid,
	output logic                             end_of_run,
	output logic        [pirl_pkg::CNT_W-1:0]  element_count,
	output logic                             is_empty,
	output logic                             is_full
);
	import pirl_pkg::*;

	localparam int SLOTS = (DEPTH < MAX_SLOTS) ? DEPTH : MAX_SLOTS;
	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [DATA_W-1:0] entries_q [SLOTS];
	logic [DATA_W-1:0] up_src    [SLOTS];  // neighbor below, for insert
	logic [DATA_W-1:0] dn_src    [SLOTS];  // neighbor above, for remove

	logic [ACT_W-1:0]  op_q;
	logic [POS_W-1:0]  pos_q;
	logic [DATA_W-1:0] val_q;
	logic [CNT_W-1:0]  count_q;
	logic [CAP_W-1:0]  cap_q;
	logic [IDX_W-1:0]  ptr_q;

	logic [CAP_W-1:0]  eff_cap;
	logic              full_now;
	logic [STAT_W-1:0] status_c;
	logic [CNT_W-1:0]  cnt_nxt;
	logic              dump_last;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] data_q;
	logic              elem_valid_q;
	logic              last_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              empty_q;
	logic              full_q;

	for (genvar g = 0; g < SLOTS; g++) begin : g_nbr
		if (g > 0) begin : g_up
			assign up_src[g] = entries_q[g-1];
		end else begin : g_up0
			assign up_src[g] = '0;
		end
		if (g < SLOTS - 1) begin : g_dn
			assign dn_src[g] = entries_q[g+1];
		end else begin : g_dn_top
			assign dn_src[g] = '0;
		end
	end

	// capacity clamped to 1..SLOTS
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CAP_W'(1);
		end else if (cap_q > CAP_W'(SLOTS)) begin
			eff_cap = CAP_W'(SLOTS);
		end else begin
			eff_cap = cap_q;
		end
	end

	assign full_now = (count_q >= eff_cap);

	always_comb begin
		status_c = STAT_OK;
		cnt_nxt  = count_q;
		case (op_q)
			ACT_APPEND: begin
				if (full_now) begin
					status_c = STAT_FULL;
				end else begin
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			ACT_INSERT: begin
				// position checked before fullness
				if (pos_q > count_q) begin
					status_c = STAT_BAD_POS;
				end else if (full_now) begin
					status_c = STAT_FULL;
				end else begin
					cnt_nxt = count_q + CNT_W'(1);
				end
			end
			ACT_REMOVE: begin
				if (pos_q >= count_q) begin
					status_c = STAT_BAD_POS;
				end else begin
					cnt_nxt = count_q - CNT_W'(1);
				end
			end
			default: begin
				status_c = STAT_OK;
			end
		endcase
	end

	assign dump_last = ((CNT_W'(ptr_q) + CNT_W'(1)) == count_q);

	assign stat.out_free   = !out_valid_q || !out_stall;
	assign stat.is_dump    = (op_q == ACT_DUMP);
	assign stat.count_zero = (count_q == '0);
	assign stat.dump_last  = dump_last;

	// input word latch
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= action;
			pos_q <= position;
			val_q <= item_value;
		end
	end

	// entry bank: every slot updates in parallel
	always_ff @(posedge clk) begin
		if (cmd.exec && status_c == STAT_OK) begin
			for (int i = 0; i < SLOTS; i++) begin
				case (op_q)
					ACT_APPEND: begin
						if (CNT_W'(i) == count_q) begin
							entries_q[i] <= val_q;
						end
					end
					ACT_INSERT: begin
						if (CNT_W'(i) == pos_q) begin
							entries_q[i] <= val_q;
						end else if (CNT_W'(i) > pos_q && CNT_W'(i) <= count_q) begin
							entries_q[i] <= up_src[i];
						end
					end
					ACT_REMOVE: begin
						if (CNT_W'(i) >= pos_q && CNT_W'(i + 1) < count_q) begin
							entries_q[i] <= dn_src[i];
						end
					end
					default: begin
						entries_q[i] <= entries_q[i];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cap_q   <= CAP_RESET;
			ptr_q   <= '0;
		end else begin
			if (cfg_write_en) begin
				cap_q <= cfg_write_data;
			end
			if (cmd.exec) begin
				count_q <= cnt_nxt;
			end
			if (cmd.ptr_clr) begin
				ptr_q <= '0;
			end else if (cmd.emit) begin
				ptr_q <= ptr_q + IDX_W'(1);
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q     <= status_c;
			data_q       <= '0;
			elem_valid_q <= 1'b0;
			last_q       <= 1'b1;
			out_count_q  <= cnt_nxt;
			empty_q      <= (cnt_nxt == '0);
			full_q       <= (cnt_nxt >= eff_cap);
		end else if (cmd.emit) begin
			status_q     <= STAT_OK;
			data_q       <= entries_q[ptr_q];
			elem_valid_q <= 1'b1;
			last_q       <= dump_last;
			out_count_q  <= count_q;
			empty_q      <= 1'b0;
			full_q       <= full_now;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign element_data  = data_q;
	assign element_valid = elem_valid_q;
	assign end_of_run    = last_q;
	assign element_count = out_count_q;
	assign is_empty      = empty_q;
	assign is_full       = full_q;

endmodule

### hdl/pirl_checker.sv
// Port-level checks for the list, bound to the top level.
`include "positional_insert_remove_list_top_defines.svh"

module pirl_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic signed [pirl_pkg::DATA_W-1:0] element_data,
	input logic                             element_valid,
	input logic                             end_of_run,
	input logic        [pirl_pkg::CNT_W-1:0]  element_count,
	input logic                             is_empty
);
	import pirl_pkg::*;

	// a stalled output word holds
	`PIRL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(element_data), "output word changed while stalled")

	// only one word in flight: the cycle after an accept is busy
	`PIRL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input taken twice in a row")

	// a word without an element is always the only, hence final, result
	`PIRL_ASSERT_NOW(a_single_is_last, out_valid && !element_valid, end_of_run, "single result not marked final")

	// a dumped element implies a nonempty list with matching flags
	`PIRL_ASSERT_NOW(a_elem_nonempty, out_valid && element_valid, !is_empty && element_count != '0, "element shown from empty list")

endmodule

bind positional_insert_remove_list_top pirl_checker u_pirl_checker (.*);
